[rtl/bhfs_pkg.sv]
// shared constants and types for the bitmap hole fit search block
package bhfs_pkg;

   // field widths of the transfer payloads
   localparam int REQ_TYPE_W  = 1;
   localparam int WORD_IDX_W  = 5;
   localparam int WORD_DATA_W = 32;
   localparam int REQ_SIZE_W  = 11;
   localparam int BASE_W      = 10;
   localparam int HOLE_W      = 11;

   // control register port
   localparam int MODE_W     = 2;
   localparam int UNITS_W    = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   localparam logic [UNITS_W-1:0] UNITS_RESET = 11'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_MODE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_UNITS = 1'd1;

   // placement policies, unused code behaves as first fit
   localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE  = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SEARCH = 1'b1;

   // commands from the scan sequencer to the run tracker
   typedef struct packed {
      logic clear;
      logic close;
   } track_ctl_type;

endpackage

[rtl/bhfs_chan_if.sv]
// request and response channel interfaces
interface bhfs_req_if;
   logic                                valid;
   logic                                ready;
   logic [bhfs_pkg::REQ_TYPE_W-1:0]     req_type;
   logic [bhfs_pkg::WORD_IDX_W-1:0]     word_index;
   logic [bhfs_pkg::WORD_DATA_W-1:0]    word_bits;
   logic [bhfs_pkg::REQ_SIZE_W-1:0]     request_size;

   modport source (output valid, req_type, word_index, word_bits, request_size,
                   input ready);
   modport sink   (input valid, req_type, word_index, word_bits, request_size,
                   output ready);
endinterface

interface bhfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [bhfs_pkg::BASE_W-1:0]    base_unit;
   logic [bhfs_pkg::HOLE_W-1:0]    hole_length;

   modport source (output valid, found, base_unit, hole_length, input ready);
   modport sink   (input valid, found, base_unit, hole_length, output ready);
endinterface

[rtl/bhfs_best_track.sv]
// run evaluation unit: compares each closed free run and keeps the chosen one
module bhfs_best_track #(
   parameter int LEN_W  = 11,
   parameter int UNIT_W = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bhfs_pkg::track_ctl_type             ctl,
   input  logic [bhfs_pkg::MODE_W-1:0]         fit_mode,
   input  logic [bhfs_pkg::REQ_SIZE_W-1:0]     need,
   input  logic [UNIT_W-1:0]                   run_start,
   input  logic [LEN_W-1:0]                    run_len,
   output logic                                stop,
   output logic                                have,
   output logic [UNIT_W-1:0]                   best_base,
   output logic [LEN_W-1:0]                    best_len
);

   localparam int CMP_W = (LEN_W > bhfs_pkg::REQ_SIZE_W) ? LEN_W : bhfs_pkg::REQ_SIZE_W;

   logic              have_ff, have_in;
   logic [UNIT_W-1:0] best_base_ff;
   logic [LEN_W-1:0]  best_len_ff;
   logic              fits, is_best, is_worst, take;

   // compare logic for every fit mode
   always_comb begin
      fits     = CMP_W'(run_len) >= CMP_W'(need);
      is_best  = (fit_mode == bhfs_pkg::FIT_BEST);
      is_worst = (fit_mode == bhfs_pkg::FIT_WORST);
      take     = ctl.close && fits &&
                 (!have_ff || (is_best && (run_len < best_len_ff)) ||
                  (is_worst && (run_len > best_len_ff)));
      stop     = ctl.close && fits && !have_ff && !is_best && !is_worst;
      have_in  = ctl.clear ? 1'b0 : (have_ff || take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
   end

   // chosen run payload
   always_ff @(posedge clock) begin
      if (take) begin
         best_base_ff <= run_start;
         best_len_ff  <= run_len;
      end
   end

   assign have      = have_ff;
   assign best_base = best_base_ff;
   assign best_len  = best_len_ff;

endmodule

[rtl/bhfs_scan_engine.sv]
// scan sequencer: bitmap memory, clearing pass, run tracking and response register
module bhfs_scan_engine #(
   parameter int MAP_BITS  = 1024,
   parameter int WORD_BITS = 32,
   parameter int U_W       = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   bhfs_req_if.sink                      req_ch,
   bhfs_rsp_if.source                    rsp_ch,
   input  logic [bhfs_pkg::MODE_W-1:0]   fit_mode,
   input  logic [U_W-1:0]                limit
);

   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int W_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int O_W       = $clog2(WORD_BITS);
   localparam int UNIT_W    = $clog2(MAP_BITS);
   localparam int S_W       = U_W + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [W_W-1:0]                    clr_ff, clr_in;
   logic [U_W-1:0]                    u_ff, u_in;
   logic [W_W-1:0]                    word_ff, word_in;
   logic [O_W-1:0]                    off_ff, off_in;
   logic                              run_open_ff, run_open_in;
   logic [UNIT_W-1:0]                 run_start_ff, run_start_in;
   logic [U_W-1:0]                    run_len_ff, run_len_in;
   logic [bhfs_pkg::REQ_SIZE_W-1:0]   need_ff, need_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [bhfs_pkg::BASE_W-1:0]       rsp_base_ff, rsp_base_in;
   logic [bhfs_pkg::HOLE_W-1:0]       rsp_len_ff, rsp_len_in;

   logic [WORD_BITS-1:0]              mem_ff [MAP_WORDS];
   logic [WORD_BITS-1:0]              rd_data_ff;
   logic                              mem_we;
   logic [W_W-1:0]                    mem_waddr;
   logic [WORD_BITS-1:0]              mem_wdata;

   logic                              req_fire, whole, all_free, all_used, bulk;
   logic                              step_used, word_end;
   logic [U_W-1:0]                    step, u_next;
   bhfs_pkg::track_ctl_type           trk_ctl;
   logic                              trk_stop, trk_have;
   logic [UNIT_W-1:0]                 trk_base;
   logic [U_W-1:0]                    trk_len;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // step decode: a whole free or used word within the limit moves as one step, else one unit
   always_comb begin
      whole     = (off_ff == '0) && ((S_W'(u_ff) + S_W'(WORD_BITS)) <= S_W'(limit));
      all_free  = (rd_data_ff == '0);
      all_used  = (rd_data_ff == '1);
      bulk      = whole && (all_free || all_used);
      step_used = bulk ? all_used : rd_data_ff[off_ff];
      step      = bulk ? U_W'(WORD_BITS) : U_W'(1);
      u_next    = u_ff + step;
      word_end  = bulk || (off_ff == O_W'(WORD_BITS - 1));
   end

   bhfs_best_track #(
      .LEN_W  (U_W),
      .UNIT_W (UNIT_W)
   ) u_best_track (
      .clock     (clock),
      .reset     (reset),
      .ctl       (trk_ctl),
      .fit_mode  (fit_mode),
      .need      (need_ff),
      .run_start (run_start_ff),
      .run_len   (run_len_ff),
      .stop      (trk_stop),
      .have      (trk_have),
      .best_base (trk_base),
      .best_len  (trk_len)
   );

   // sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      u_in         = u_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      run_open_in  = run_open_ff;
      run_start_in = run_start_ff;
      run_len_in   = run_len_ff;
      need_in      = need_ff;
      rsp_found_in = rsp_found_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      trk_ctl      = '0;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == W_W'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.req_type == bhfs_pkg::REQ_WRITE) begin
                  // out of range word indexes are dropped
                  mem_we    = (32'(req_ch.word_index) < 32'(MAP_WORDS));
                  mem_waddr = W_W'(req_ch.word_index);
                  mem_wdata = WORD_BITS'(req_ch.word_bits);
               end else begin
                  need_in       = (req_ch.request_size == '0) ?
                                  bhfs_pkg::REQ_SIZE_W'(1) : req_ch.request_size;
                  u_in          = '0;
                  word_in       = '0;
                  off_in        = '0;
                  run_open_in   = 1'b0;
                  trk_ctl.clear = 1'b1;
                  state_in      = (limit == '0) ? ST_EMIT : ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (step_used) begin
               trk_ctl.close = run_open_ff;
               run_open_in   = 1'b0;
            end else if (!run_open_ff) begin
               run_open_in  = 1'b1;
               run_start_in = UNIT_W'(u_ff);
               run_len_in   = step;
            end else begin
               run_len_in = run_len_ff + step;
            end
            u_in    = u_next;
            off_in  = word_end ? '0 : off_ff + 1'b1;
            word_in = word_end ? word_ff + 1'b1 : word_ff;
            if (trk_stop) begin
               state_in = ST_EMIT;
            end else if (u_next >= limit) begin
               state_in = ST_FINISH;
            end else if (word_end) begin
               state_in = ST_FETCH;
            end
         end
         ST_FINISH: begin
            // a run that reaches the search limit closes here
            trk_ctl.close = run_open_ff;
            run_open_in   = 1'b0;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = trk_have;
               rsp_base_in  = trk_have ? bhfs_pkg::BASE_W'(trk_base) : '0;
               rsp_len_in   = trk_have ? bhfs_pkg::HOLE_W'(trk_len) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      u_ff         <= u_in;
      word_ff      <= word_in;
      off_ff       <= off_in;
      run_open_ff  <= run_open_in;
      run_start_ff <= run_start_in;
      run_len_ff   <= run_len_in;
      need_ff      <= need_in;
      rsp_found_ff <= rsp_found_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_len_ff   <= rsp_len_in;
   end

   // bitmap memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_FETCH) begin
         rd_data_ff <= mem_ff[word_ff];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.base_unit   = rsp_base_ff;
   assign rsp_ch.hole_length = rsp_len_ff;

endmodule

[rtl/bitmap_hole_fit_search.sv]
// top level: control registers and the bitmap scan engine
// a search fetches each bitmap word in turn; a word that lies wholly within the limit and is
//   wholly free or wholly used moves as one step, a mixed word one unit at a time
// first fit stops at the first run that fits; the response is registered
// the one-unit-per-cycle step through mixed words and the single memory read port bound the search
// reset is synchronous; afterwards a clearing pass zeroes the bitmap word by word,
//   with no request taken meanwhile; configuration writes are always taken
module bitmap_hole_fit_search #(
   parameter int MAP_BITS  = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   bhfs_req_if.sink                          req_ch,
   bhfs_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [bhfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bhfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int U_W = $clog2(MAP_BITS + 1);

   logic [bhfs_pkg::MODE_W-1:0]  fit_mode_ff, fit_mode_in;
   logic [bhfs_pkg::UNITS_W-1:0] map_units_ff, map_units_in;
   logic [U_W-1:0]               limit;

   // control register writes
   always_comb begin
      fit_mode_in  = fit_mode_ff;
      map_units_in = map_units_ff;
      if (csr_we) begin
         case (csr_index)
            bhfs_pkg::CSR_FIT_MODE:  fit_mode_in  = csr_wdata[bhfs_pkg::MODE_W-1:0];
            bhfs_pkg::CSR_MAP_UNITS: map_units_in = bhfs_pkg::UNITS_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= bhfs_pkg::FIT_FIRST;
         map_units_ff <= bhfs_pkg::UNITS_RESET;
      end else begin
         fit_mode_ff  <= fit_mode_in;
         map_units_ff <= map_units_in;
      end
   end

   // search limit saturates at the map size
   assign limit = (32'(map_units_ff) > 32'(MAP_BITS)) ? U_W'(MAP_BITS) : U_W'(map_units_ff);

   bhfs_scan_engine #(
      .MAP_BITS  (MAP_BITS),
      .WORD_BITS (WORD_BITS),
      .U_W       (U_W)
   ) u_scan_engine (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .fit_mode (fit_mode_ff),
      .limit    (limit)
   );

endmodule

[rtl/bhfs_checker.sv]
// port level checks for the bitmap hole fit search block, bound to the top level
module bhfs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_found,
   input logic [bhfs_pkg::BASE_W-1:0]   rsp_base_unit,
   input logic [bhfs_pkg::HOLE_W-1:0]   rsp_hole_length
);

   // a pending response stays until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // a miss reports zero base and length
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_base_unit == '0) && (rsp_hole_length == '0))
      else $error("miss response carries nonzero payload");

   // a hit always names a nonempty run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> (rsp_hole_length != '0))
      else $error("hit response with zero length run");

   // request ready is low right after reset, at the start of the bitmap clearing pass
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

endmodule

bind bitmap_hole_fit_search bhfs_checker u_bhfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_found       (rsp_ch.found),
   .rsp_base_unit   (rsp_ch.base_unit),
   .rsp_hole_length (rsp_ch.hole_length)
);
